### hw/rtl/sobel_edge_magnitude_assert.svh
// Assertion macros shared by the sobel edge magnitude checker.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define SEM_ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SEM_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/sem_pkg.sv
// Shared types and constants of the sobel edge magnitude block.
package sem_pkg;

   localparam int PIX_BITS  = 8;   // pixel and magnitude width
   localparam int COL_BITS  = 11;  // image_width register and column counter
   localparam int ROW_BITS  = 12;  // image_height register and row counter
   localparam int GRAD_BITS = 11;  // signed gx / gy, range +-1020
   localparam int SQ_BITS   = 20;  // one squared gradient, at most 1040400

   // configuration as seen by the datapath
   typedef struct packed {
      logic [COL_BITS-1:0] width;
      logic [ROW_BITS-1:0] height;
   } cfg_type;

   // gradient pair handed from the window to the magnitude pipeline
   typedef struct packed {
      logic                        valid;
      logic signed [GRAD_BITS-1:0] gx;
      logic signed [GRAD_BITS-1:0] gy;
      logic                        row_end;
      logic                        frame_end;
   } grad_type;

endpackage

### hw/rtl/sem_req_if.sv
// Pixel input channel: valid / ready handshake with one pixel per item.
interface sem_req_if import sem_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

### hw/rtl/sem_rsp_if.sv
// Result channel: valid / ready handshake carrying magnitude and end flags.
interface sem_rsp_if import sem_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] magnitude;
   logic                row_end;
   logic                frame_end;

   modport source (output valid, output magnitude, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input magnitude, input row_end, input frame_end,
                   output ready);
endinterface

### hw/rtl/sem_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sem_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] rd_data_in;

   // read returns the old contents on a same-address write
   assign rd_data_in = mem_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= rd_data_in;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sem_csr.sv
// Configuration registers image_width and image_height on an APB-style port.
module sem_csr import sem_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [COL_BITS-1:0] WIDTH_RESET  = COL_BITS'(481);
   localparam logic [ROW_BITS-1:0] HEIGHT_RESET = ROW_BITS'(321);

   logic                index;
   logic                wr_strobe;
   logic [COL_BITS-1:0] width_ff, width_in;
   logic [ROW_BITS-1:0] height_ff, height_in;

   // registers sit at byte addresses 0 and 4
   assign index     = paddr[2];
   assign wr_strobe = psel & penable & pwrite;
   assign pready    = 1'b1;

   // write decode
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_strobe) begin
         unique case (index)
            REG_WIDTH:  width_in  = pwdata[COL_BITS-1:0];
            REG_HEIGHT: height_in = pwdata[ROW_BITS-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // read mux
   always_comb begin
      unique case (index)
         REG_WIDTH:  prdata = {{(32-COL_BITS){1'b0}}, width_ff};
         REG_HEIGHT: prdata = {{(32-ROW_BITS){1'b0}}, height_ff};
         default:    prdata = '0;
      endcase
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

endmodule

### hw/rtl/sem_window.sv
// Raster counters, line store RAM read-modify-write, 3x3 window and Sobel gradients.
module sem_window import sem_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   input  logic [PIX_BITS-1:0] in_pixel,
   input  logic                advance,
   output grad_type            grad
);

   localparam int AW        = $clog2(MAX_WIDTH);
   localparam int COL_LIMIT = (1 << COL_BITS) - 1;
   localparam logic [COL_BITS-1:0] W_MAX =
      COL_BITS'(MAX_WIDTH > COL_LIMIT ? COL_LIMIT : MAX_WIDTH);
   localparam logic [COL_BITS-1:0] W_MIN = COL_BITS'(3);
   localparam logic [ROW_BITS-1:0] H_MIN = ROW_BITS'(3);

   typedef struct packed {
      logic                valid;
      logic                emit;
      logic                row_end;
      logic                frame_end;
      logic [PIX_BITS-1:0] px;
      logic [AW-1:0]       addr;
   } fetch_type;

   logic                accept;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] width_eff;
   logic [ROW_BITS-1:0] height_eff;
   logic                last_col, last_row, emit;
   fetch_type           s1_ff, s1_in;
   logic [2*PIX_BITS-1:0] rd_data;
   logic [PIX_BITS-1:0] win_ff [9];
   logic [PIX_BITS-1:0] win_in [9];
   logic signed [GRAD_BITS-1:0] p [9];
   grad_type            grad_ff, grad_in;

   assign accept = in_valid & advance;

   // effective image size and position of the incoming pixel
   always_comb begin
      if (cfg.width < W_MIN) begin
         width_eff = W_MIN;
      end else if (cfg.width > W_MAX) begin
         width_eff = W_MAX;
      end else begin
         width_eff = cfg.width;
      end
      height_eff = (cfg.height < H_MIN) ? H_MIN : cfg.height;
      last_col   = col_ff >= (width_eff - 1'b1);
      last_row   = row_ff >= (height_eff - 1'b1);
      emit       = (row_ff >= ROW_BITS'(2)) && (col_ff >= COL_BITS'(2));
   end

   // raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // fetch stage: holds the pixel while the line store read is in flight
   always_comb begin
      s1_in.valid     = accept;
      s1_in.emit      = emit;
      s1_in.row_end   = last_col;
      s1_in.frame_end = last_col & last_row;
      s1_in.px        = in_pixel;
      s1_in.addr      = AW'(col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
      end
   end

   // both line stores share one entry: upper byte is the older row
   // write-back lands before any later read of the same column
   sem_ram #(
      .WIDTH (2*PIX_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance & s1_ff.valid),
      .wr_addr (s1_ff.addr),
      .wr_data ({rd_data[PIX_BITS-1:0], s1_ff.px}),
      .rd_en   (accept),
      .rd_addr (AW'(col_ff)),
      .rd_data (rd_data)
   );

   // window shifts left; right column takes top, middle and new pixel
   always_comb begin
      win_in = win_ff;
      if (s1_ff.valid) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k*3]   = win_ff[k*3+1];
            win_in[k*3+1] = win_ff[k*3+2];
         end
         win_in[2] = rd_data[2*PIX_BITS-1:PIX_BITS];
         win_in[5] = rd_data[PIX_BITS-1:0];
         win_in[8] = s1_ff.px;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (advance) begin
         win_ff <= win_in;
      end
   end

   // Sobel kernels on the updated window
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         p[k] = signed'({{(GRAD_BITS-PIX_BITS){1'b0}}, win_in[k]});
      end
      grad_in.valid     = s1_ff.valid & s1_ff.emit;
      grad_in.gx        = (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
      grad_in.gy        = (p[6] - p[0]) + ((p[7] - p[1]) <<< 1) + (p[8] - p[2]);
      grad_in.row_end   = s1_ff.row_end;
      grad_in.frame_end = s1_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grad_ff.valid <= 1'b0;
      end else if (advance) begin
         grad_ff <= grad_in;
      end
   end

   assign grad = grad_ff;

endmodule

### hw/rtl/sem_mag.sv
// Magnitude pipeline: squares, sum with saturation, two-stage integer square root.
module sem_mag import sem_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  grad_type         grad,
   output logic             advance,
   sem_rsp_if.source        rsp
);

   localparam int ROOT_BITS = 2*PIX_BITS;

   typedef struct packed {
      logic               valid;
      logic               row_end;
      logic               frame_end;
      logic [SQ_BITS-1:0] sqx;
      logic [SQ_BITS-1:0] sqy;
   } sq_stage_type;

   typedef struct packed {
      logic [ROOT_BITS-1:0] rem;
      logic [ROOT_BITS-1:0] root;
   } root_type;

   typedef struct packed {
      logic     valid;
      logic     row_end;
      logic     frame_end;
      logic     sat;
      root_type st;
   } root_stage_type;

   typedef struct packed {
      logic                valid;
      logic [PIX_BITS-1:0] magnitude;
      logic                row_end;
      logic                frame_end;
   } out_type;

   // one restoring step of the digit-by-digit square root
   function automatic root_type root_step(root_type s, int shift);
      logic [ROOT_BITS-1:0] bitv;
      logic [ROOT_BITS:0]   trial;
      root_type             r;
      bitv  = {{(ROOT_BITS-1){1'b0}}, 1'b1} << shift;
      trial = {1'b0, s.root} + {1'b0, bitv};
      r     = s;
      if ({1'b0, s.rem} >= trial) begin
         r.rem  = s.rem - trial[ROOT_BITS-1:0];
         r.root = (s.root >> 1) + bitv;
      end else begin
         r.root = s.root >> 1;
      end
      return r;
   endfunction

   logic signed [2*GRAD_BITS-1:0] prod_x, prod_y;
   logic [SQ_BITS:0]  sum;
   sq_stage_type      s3_ff, s3_in;
   root_stage_type    s4_ff, s4_in;
   root_stage_type    s5_ff, s5_in;
   root_type          tail;
   out_type           out_ff, out_in;

   // whole pipeline moves unless a result is held at the output
   assign advance = !out_ff.valid || rsp.ready;

   // squares
   always_comb begin
      prod_x          = grad.gx * grad.gx;
      prod_y          = grad.gy * grad.gy;
      s3_in.valid     = grad.valid;
      s3_in.row_end   = grad.row_end;
      s3_in.frame_end = grad.frame_end;
      s3_in.sqx       = prod_x[SQ_BITS-1:0];
      s3_in.sqy       = prod_y[SQ_BITS-1:0];
   end

   // sum; anything from 65536 up saturates
   always_comb begin
      sum             = {1'b0, s3_ff.sqx} + {1'b0, s3_ff.sqy};
      s4_in.valid     = s3_ff.valid;
      s4_in.row_end   = s3_ff.row_end;
      s4_in.frame_end = s3_ff.frame_end;
      s4_in.sat       = |sum[SQ_BITS:ROOT_BITS];
      s4_in.st.rem    = sum[ROOT_BITS-1:0];
      s4_in.st.root   = '0;
   end

   // upper four root bits
   always_comb begin
      s5_in = s4_ff;
      for (int i = 0; i < 4; i++) begin
         s5_in.st = root_step(s5_in.st, ROOT_BITS - 2 - 2*i);
      end
   end

   // lower four root bits and output selection
   always_comb begin
      tail = s5_ff.st;
      for (int i = 0; i < 4; i++) begin
         tail = root_step(tail, ROOT_BITS/2 - 2 - 2*i);
      end
      out_in.valid     = s5_ff.valid;
      out_in.magnitude = s5_ff.sat ? {PIX_BITS{1'b1}} : tail.root[PIX_BITS-1:0];
      out_in.row_end   = s5_ff.row_end;
      out_in.frame_end = s5_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid  <= 1'b0;
         s4_ff.valid  <= 1'b0;
         s5_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         out_ff <= out_in;
      end
   end

   assign rsp.valid     = out_ff.valid;
   assign rsp.magnitude = out_ff.magnitude;
   assign rsp.row_end   = out_ff.row_end;
   assign rsp.frame_end = out_ff.frame_end;

endmodule

### hw/rtl/sobel_edge_magnitude.sv
// Top level of the Sobel 3x3 gradient magnitude block.
// Throughput: one pixel per clock if not stalled; line RAM does a read and a write a cycle.
// The last pixel of a window passes the s1, grad, s3, s4, s5 and out registers before rsp.
// A held result stalls the whole pipeline, and req.ready drops with it.
// Reset clears counters, window, pipeline valids and sets registers to 481 x 321.
module sobel_edge_magnitude import sem_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   sem_req_if.sink     req,
   sem_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type  cfg;
   grad_type grad;
   logic     advance;

   assign req.ready = advance;

   // configuration registers
   sem_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // line stores, window and gradients
   sem_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req.valid),
      .in_pixel (req.pixel),
      .advance  (advance),
      .grad     (grad)
   );

   // magnitude and output register
   sem_mag u_mag (
      .clock   (clock),
      .reset   (reset),
      .grad    (grad),
      .advance (advance),
      .rsp     (rsp)
   );

endmodule

### hw/rtl/sem_checker.sv
// Port-level assertions for the Sobel edge magnitude block, with its bind.
`include "sobel_edge_magnitude_assert.svh"

module sem_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_row_end,
   input logic rsp_frame_end
);

   // a stalled result stays offered
   `SEM_ASSERT_RUN(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped while stalled")

   // the last result of a frame also closes its row
   `SEM_ASSERT_RUN(a_frame_row, clock, reset, rsp_valid && rsp_frame_end |-> rsp_row_end, "frame end without row end")

   // input is held off only by a result waiting at the output
   `SEM_ASSERT_RUN(a_req_stall, clock, reset, !req_ready |-> (rsp_valid && !rsp_ready), "input stalled without output backpressure")

   // reset empties the output register
   `SEM_ASSERT_ALL(a_reset_clear, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_row_end   (rsp.row_end),
   .rsp_frame_end (rsp.frame_end)
);

### tb/sv/tb_sobel_edge_magnitude.sv
// Self-checking testbench for the Sobel 3x3 gradient magnitude block.
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude;
   import sem_pkg::*;

   localparam int MAX_W         = 1024;
   localparam int DRAIN_CYCLES  = 16;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int RANDOM_ITEMS  = 480;
   localparam int PRESSURE_HOLD = 300;

   // register byte addresses
   typedef enum logic [2:0] {
      CSR_WIDTH  = 3'd0,
      CSR_HEIGHT = 3'd4
   } csr_addr_type;

   // pixel content styles for random frames
   typedef enum int {
      PIX_NOISE,
      PIX_BINARY,
      PIX_SMOOTH,
      PIX_FLAT
   } pix_style_type;

   // Predicts magnitudes from accepted pixels and checks the results in order.
   class edge_scoreboard;
      typedef struct {
         bit [PIX_BITS-1:0] magnitude;
         bit                row_end;
         bit                frame_end;
      } edge_result_type;

      bit [COL_BITS-1:0] width_reg;
      bit [ROW_BITS-1:0] height_reg;
      bit [PIX_BITS-1:0] prev_row [MAX_W];
      bit [PIX_BITS-1:0] older_row [MAX_W];
      bit [PIX_BITS-1:0] win [9];
      int                col;
      int                row;
      edge_result_type   expected_q [$];
      int                failures;

      function new();
         width_reg  = 481;
         height_reg = 321;
         foreach (prev_row[i]) begin
            prev_row[i]  = '0;
            older_row[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         col      = 0;
         row      = 0;
         failures = 0;
      endfunction

      function void set_register(csr_addr_type addr, logic [31:0] value);
         case (addr)
            CSR_WIDTH:  width_reg  = value[COL_BITS-1:0];
            CSR_HEIGHT: height_reg = value[ROW_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(csr_addr_type addr);
         return (addr == CSR_WIDTH) ? 32'(width_reg) : 32'(height_reg);
      endfunction

      function int eff_width();
         int w;
         w = width_reg;
         if (w < 3) w = 3;
         if (w > MAX_W) w = MAX_W;
         return w;
      endfunction

      function int eff_height();
         int h;
         h = height_reg;
         if (h < 3) h = 3;
         return h;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // pixels still needed until the counters wrap at the end of the frame
      function int frame_pixels_left();
         int w, h, c, r, n;
         w = eff_width();
         h = eff_height();
         c = col;
         r = row;
         n = 0;
         forever begin
            n++;
            if (c >= w - 1) begin
               if (r >= h - 1) return n;
               c = 0;
               r++;
            end else begin
               c++;
            end
         end
      endfunction

      // floor of the square root, saturated to 255
      function bit [PIX_BITS-1:0] floor_root(int unsigned s);
         int unsigned r, t;
         if (s >= 65536) return 8'hFF;
         r = 0;
         for (int b = 7; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= s) r = t;
         end
         return r[PIX_BITS-1:0];
      endfunction

      // advance line stores, window and counters; queue a magnitude if due
      function void note_pixel(bit [PIX_BITS-1:0] px);
         int w, h, gx, gy;
         int p [9];
         bit [PIX_BITS-1:0] top, mid;
         bit last_col, last_row;
         edge_result_type res;
         w = eff_width();
         h = eff_height();
         top = older_row[col];
         mid = prev_row[col];
         older_row[col] = mid;
         prev_row[col]  = px;
         for (int k = 0; k < 3; k++) begin
            win[k*3 + 0] = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = px;
         last_col = (col >= w - 1);
         last_row = (row >= h - 1);
         if (row >= 2 && col >= 2) begin
            foreach (p[k]) p[k] = int'(win[k]);
            gx = (p[2] - p[0]) + 2 * (p[5] - p[3]) + (p[8] - p[6]);
            gy = (p[6] - p[0]) + 2 * (p[7] - p[1]) + (p[8] - p[2]);
            res.magnitude = floor_root(gx * gx + gy * gy);
            res.row_end   = last_col;
            res.frame_end = last_col && last_row;
            expected_q.push_back(res);
         end
         if (last_col) begin
            col = 0;
            row = last_row ? 0 : row + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      function void compare_field(string name, int want, logic [31:0] got);
         if (got !== want) begin
            $error("mismatch on %s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(logic [PIX_BITS-1:0] mag, logic row_end, logic frame_end);
         edge_result_type want;
         if (expected_q.size() == 0) begin
            $error("result with nothing pending: magnitude %0d", mag);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("magnitude", want.magnitude, 32'(mag));
         compare_field("row_end", want.row_end, 32'(row_end));
         compare_field("frame_end", want.frame_end, 32'(frame_end));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sem_req_if req ();
   sem_rsp_if rsp ();

   edge_scoreboard sb = new();

   int req_idle_pct     = 17;
   int rsp_idle_pct     = 17;
   int rsp_hold_request = 0;
   int cycle_count      = 0;

   sobel_edge_magnitude #(.MAX_WIDTH(MAX_W)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_sobel_edge_magnitude failed");
         $finish;
      end
   end

   // result ready: random stalls, plus a long hold on request
   initial begin : rsp_ready_gen
      int hold_left;
      hold_left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (reset) begin
            rsp.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // handshake monitor: check results first, then note the accepted pixel
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) sb.check_result(rsp.magnitude, rsp.row_end, rsp.frame_end);
         if (req.valid && req.ready) sb.note_pixel(req.pixel);
      end
   end

   // offer one pixel, with random gaps ahead of it, and wait for acceptance
   task automatic drive_pixel(input logic [PIX_BITS-1:0] px);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.pixel <= px;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   function automatic logic [PIX_BITS-1:0] pick_pixel(pix_style_type style,
                                                      logic [PIX_BITS-1:0] base);
      case (style)
         PIX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
         PIX_SMOOTH: return base + 8'($urandom_range(7));
         PIX_FLAT:   return base;
         default:    return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_pixels(input int count, input pix_style_type style);
      logic [PIX_BITS-1:0] base;
      base = 8'($urandom_range(248));
      for (int k = 0; k < count; k++) drive_pixel(pick_pixel(style, base));
   endtask

   // stop offering and wait until every predicted magnitude has come back
   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB read, compared with the register copy in the scoreboard
   task automatic check_csr(input csr_addr_type addr);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      sb.compare_field(addr.name(), sb.register_value(addr), got);
   endtask

   // APB write, then read back
   task automatic write_csr(input csr_addr_type addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_register(addr, value);
      check_csr(addr);
   endtask

   initial begin
      int n, phase, random_items;
      pix_style_type style;

      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.pixel   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the size registers
      check_csr(CSR_WIDTH);
      check_csr(CSR_HEIGHT);

      // directed: both sizes below the minimum, so 3x3 frames with one result each
      write_csr(CSR_WIDTH, 32'd0);
      write_csr(CSR_HEIGHT, 32'd2);
      for (int k = 0; k < 9; k++) drive_pixel(8'h00);
      // vertical step edge: the magnitude saturates
      for (int k = 0; k < 9; k++) drive_pixel((k % 3 == 2) ? 8'hFF : 8'h00);
      // one small corner value: magnitude below saturation
      for (int k = 0; k < 9; k++) drive_pixel((k == 8) ? 8'h03 : 8'h00);
      wait_drained();

      // random frames, mostly small
      phase        = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase == 2) begin
            // pressure: results held off while a wider frame streams in
            write_csr(CSR_WIDTH, 32'd20);
            write_csr(CSR_HEIGHT, 32'd6);
            rsp_hold_request = PRESSURE_HOLD;
         end else begin
            if ($urandom_range(3) != 0)
               write_csr(CSR_WIDTH, ($urandom_range(9) == 0) ? $urandom_range(2)
                                                             : $urandom_range(3, 14));
            if ($urandom_range(3) != 0)
               write_csr(CSR_HEIGHT, ($urandom_range(9) == 0) ? $urandom_range(2)
                                                              : $urandom_range(3, 9));
         end
         // long stretch with no idling on either side
         if (phase == 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if (phase == 6) begin
            req_idle_pct = 17;
            rsp_idle_pct = 17;
         end
         style = pix_style_type'($urandom_range(3));
         // broken frame: sizes change part way through
         if (phase != 2 && $urandom_range(4) == 0) begin
            n = $urandom_range(1, sb.frame_pixels_left() - 1);
            send_pixels(n, style);
            random_items += n;
            wait_drained();
            if ($urandom_range(1))
               write_csr(CSR_HEIGHT, $urandom_range(9));
            else
               write_csr(CSR_WIDTH, $urandom_range(sb.eff_width()));  // shrink only
         end
         n = sb.frame_pixels_left();
         send_pixels(n, style);
         random_items += n;
         wait_drained();
         phase++;
      end

      // tallest frame, cut short by a height change part way through
      write_csr(CSR_WIDTH, 32'd3);
      write_csr(CSR_HEIGHT, 32'd4095);
      send_pixels(12, PIX_NOISE);
      wait_drained();
      write_csr(CSR_HEIGHT, 32'd3);
      send_pixels(sb.frame_pixels_left(), PIX_NOISE);
      wait_drained();

      if (sb.failures == 0)
         $display("tb_sobel_edge_magnitude passed");
      else
         $display("tb_sobel_edge_magnitude failed");
      $finish;
   end

endmodule
